[hw/rtl/r2fft_pkg.sv]
`default_nettype none
package r2fft_pkg;

  localparam int WORD_BITS   = 28;
  localparam int SAMPLE_BITS = 16;
  localparam int TW_BITS     = 16;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic REG_LOG_SIZE = 1'b0;
  localparam logic REG_INVERSE  = 1'b1;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef struct packed {
    logic [1:0]                     cmd;
    logic [9:0]                     index;
    logic signed [SAMPLE_BITS-1:0]  sample_re;
    logic signed [SAMPLE_BITS-1:0]  sample_im;
  } fft_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] bin_re;
    logic signed [WORD_BITS-1:0] bin_im;
  } fft_out_t;

  // clamp to [0, 1.0] and round onto the 32767 grid
  function automatic logic [TW_BITS-1:0] q15_of(input logic signed [63:0] c);
    logic [63:0] u;
    logic [63:0] p;
    if (c < 0) begin
      u = 64'd0;
    end else if (c > $signed(ONE_Q30)) begin
      u = ONE_Q30;
    end else begin
      u = c;
    end
    p = (u * 64'd32767 + (64'd1 << 29)) >> 30;
    return p[TW_BITS-1:0];
  endfunction

  // twiddle k of a 2^lgmax point transform: {re, im}, built by series at elaboration
  function automatic logic [2*TW_BITS-1:0] tw_calc(input int k, input int lgmax);
    logic [63:0]        npts;
    logic [63:0]        m;
    logic [63:0]        x;
    logic [63:0]        t;
    logic signed [63:0] c;
    logic signed [63:0] s;
    logic               mirror;
    logic [TW_BITS-1:0] cq;
    logic [TW_BITS-1:0] sq;
    int                 n;
    npts   = 64'd1 << lgmax;
    m      = 64'(k);
    mirror = 1'b0;
    if (64'd4 * 64'(k) > npts) begin
      m      = (npts >> 1) - 64'(k);
      mirror = 1'b1;
    end
    x = (m * 64'd2 * PI_Q30) >> lgmax;
    c = $signed(ONE_Q30);
    t = ONE_Q30;
    for (n = 2; n <= 24; n += 2) begin
      t = (t * x) >> 30;
      t = ((t * x) >> 30) / 64'((n - 1) * n);
      if (((n / 2) & 1) != 0) begin
        c = c - $signed(t);
      end else begin
        c = c + $signed(t);
      end
    end
    s = $signed(x);
    t = x;
    for (n = 3; n <= 25; n += 2) begin
      t = (t * x) >> 30;
      t = ((t * x) >> 30) / 64'((n - 1) * n);
      if ((((n - 1) / 2) & 1) != 0) begin
        s = s - $signed(t);
      end else begin
        s = s + $signed(t);
      end
    end
    cq = q15_of(c);
    sq = q15_of(s);
    return {(mirror ? -cq : cq), -sq};
  endfunction

endpackage
`default_nettype wire

[hw/rtl/radix2_fft_inplace.sv]
`default_nettype none
// In-place radix-2 decimation-in-time FFT over a store of MAX_POINTS complex
// 28-bit words. Issue a command by raising start while busy is low; every
// command answers with exactly one result word, marked by a one-cycle done
// strobe that cannot be stalled, so the receiver must take it when it comes.
// A write's zero result shows the cycle after the write is taken. A read goes
// through the memory read register, then the output register. Run walks the
// store through the single-read, single-write sample memory: a conjugate pass
// (inverse only), a bit-reversal pass, then (N/2)*log2(N) butterflies, each a
// twiddle fetch, two reads, a multiply, an add and two writes, and last a
// conjugate-and-scale pass (inverse only); N = 2^log_size, capped at
// MAX_POINTS. After reset a clearing pass zeroes the store, one entry a cycle,
// with busy held high. The user must write log_size and inverse over the APB
// port only while no command is in flight; the block does not enforce this.
module radix2_fft_inplace
  import r2fft_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire fft_in_t     req,
  output logic             done,
  output fft_out_t         result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW     = $clog2(MAX_POINTS);
  localparam int LGW    = $clog2(AW + 1);
  localparam int TDEPTH = MAX_POINTS / 2;
  localparam int TAW    = (AW > 1) ? AW - 1 : 1;
  localparam int WB     = WORD_BITS;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_READ   = 4'd2;
  localparam logic [3:0] S_PRE_RD = 4'd3;
  localparam logic [3:0] S_PRE_WR = 4'd4;
  localparam logic [3:0] S_REV    = 4'd5;
  localparam logic [3:0] S_BF_SET = 4'd6;
  localparam logic [3:0] S_RD_E   = 4'd7;
  localparam logic [3:0] S_RD_O   = 4'd8;
  localparam logic [3:0] S_SW_WE  = 4'd9;
  localparam logic [3:0] S_SW_WO  = 4'd10;
  localparam logic [3:0] S_BF_MUL = 4'd11;
  localparam logic [3:0] S_BF_ADD = 4'd12;
  localparam logic [3:0] S_BF_WE  = 4'd13;
  localparam logic [3:0] S_BF_WO  = 4'd14;
  localparam logic [3:0] S_POST   = 4'd15;

  // config registers
  logic [3:0] log_size;
  logic       inverse;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_size <= 4'd10;
      inverse  <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_LOG_SIZE: log_size <= pwdata[3:0];
        REG_INVERSE:  inverse  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LOG_SIZE: prdata = {28'd0, log_size};
      REG_INVERSE:  prdata = {31'd0, inverse};
      default:      prdata = 32'd0;
    endcase
  end

  // transform length in use, saturated to the store size
  logic [LGW-1:0] lg;
  logic [AW-1:0]  last;       // n - 1
  logic [AW-1:0]  last_bf;    // n/2 - 1
  assign lg      = ({1'b0, log_size} > 5'(AW)) ? LGW'(AW) : LGW'(log_size);
  assign last    = AW'((({(AW+1){1'b0}} | (AW+1)'(1)) << lg) - (AW+1)'(1));
  assign last_bf = last >> 1;

  // sample store, {re, im}, one write and one registered read per cycle
  logic [2*WB-1:0] mem [MAX_POINTS];
  logic            we;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   raddr;
  logic [2*WB-1:0] wdata;
  logic [2*WB-1:0] rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  logic signed [WB-1:0] rd_re;
  logic signed [WB-1:0] rd_im;
  assign rd_re = rdata[2*WB-1:WB];
  assign rd_im = rdata[WB-1:0];

  // twiddle rom, constants worked out at elaboration
  logic [2*TW_BITS-1:0] tw_rom [TDEPTH];
  for (genvar k = 0; k < TDEPTH; k++) begin : g_tw
    assign tw_rom[k] = tw_calc(k, AW);
  end

  // sequencer registers
  logic [3:0]           state;
  logic [AW-1:0]        cnt;
  logic [LGW-1:0]       stage;
  logic [AW-1:0]        e_addr;
  logic [AW-1:0]        o_addr;
  logic                 swap;
  logic [2*WB-1:0]      e_word;
  logic [2*TW_BITS-1:0] tw_q;
  logic signed [WB+TW_BITS-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [WB-1:0] t_re;
  logic signed [WB-1:0] t_im;

  assign busy = (state != S_IDLE);

  logic [AW-1:0] idx_in;
  assign idx_in = AW'(req.index);

  // bit reversal of cnt over lg bits
  logic [AW-1:0] rev_full;
  logic [AW-1:0] rev;
  always_comb begin
    for (int b = 0; b < AW; b++) begin
      rev_full[b] = cnt[AW-1-b];
    end
  end
  assign rev = rev_full >> (LGW'(AW) - lg);

  // butterfly addressing: insert a zero at bit stage-1 for the even leg
  logic [AW-1:0] half;
  logic [AW-1:0] bf_j;
  logic [AW-1:0] bf_e;
  logic [AW-1:0] tw_idx;
  assign half   = AW'(1) << (stage - LGW'(1));
  assign bf_j   = cnt & (half - AW'(1));
  assign bf_e   = ((cnt >> (stage - LGW'(1))) << stage) | bf_j;
  assign tw_idx = bf_j << (LGW'(AW) - stage);

  // product rounding, floor((p + 2^14) / 2^15)
  logic signed [WB+TW_BITS:0] sum_re;
  logic signed [WB+TW_BITS:0] sum_im;
  assign sum_re = (WB+TW_BITS+1)'(p_rr) - (WB+TW_BITS+1)'(p_ii) + (WB+TW_BITS+1)'(16384);
  assign sum_im = (WB+TW_BITS+1)'(p_ri) + (WB+TW_BITS+1)'(p_ir) + (WB+TW_BITS+1)'(16384);

  logic signed [WB-1:0] e_re;
  logic signed [WB-1:0] e_im;
  assign e_re = e_word[2*WB-1:WB];
  assign e_im = e_word[WB-1:0];

  // final inverse pass: conjugate, then divide by n rounding to nearest
  logic signed [WB-1:0] neg_im;
  logic signed [WB:0]   h;
  logic signed [WB:0]   sc_re;
  logic signed [WB:0]   sc_im;
  assign neg_im = -rd_im;
  assign h      = (lg == '0) ? '0 : ((WB+1)'(1) << (lg - LGW'(1)));
  assign sc_re  = ($signed({rd_re[WB-1], rd_re}) + h) >>> lg;
  assign sc_im  = ($signed({neg_im[WB-1], neg_im}) + h) >>> lg;

  // memory port steering
  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = '0;
    raddr = cnt;
    case (state)
      S_IDLE: begin
        raddr = idx_in;
        if (start && req.cmd == CMD_WRITE) begin
          we    = 1'b1;
          waddr = idx_in;
          wdata = {{(WB-SAMPLE_BITS){req.sample_re[SAMPLE_BITS-1]}}, req.sample_re,
                   {(WB-SAMPLE_BITS){req.sample_im[SAMPLE_BITS-1]}}, req.sample_im};
        end
      end
      S_CLEAR:  we = 1'b1;
      S_PRE_WR: begin
        we    = 1'b1;
        wdata = {rd_re, neg_im};
      end
      S_RD_E:  raddr = e_addr;
      S_RD_O:  raddr = o_addr;
      S_SW_WE: begin
        we    = 1'b1;
        waddr = e_addr;
        wdata = rdata;
      end
      S_SW_WO: begin
        we    = 1'b1;
        waddr = o_addr;
        wdata = e_word;
      end
      S_BF_WE: begin
        we    = 1'b1;
        waddr = e_addr;
        wdata = {e_re + t_re, e_im + t_im};
      end
      S_BF_WO: begin
        we    = 1'b1;
        waddr = o_addr;
        wdata = {e_re - t_re, e_im - t_im};
      end
      S_POST: begin
        if (swap) begin
          we    = 1'b1;
          wdata = {sc_re[WB-1:0], sc_im[WB-1:0]};
        end
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_BF_SET: tw_q <= tw_rom[tw_idx[TAW-1:0]];
      S_RD_O:   e_word <= rdata;
      S_BF_MUL: begin
        p_rr <= $signed(tw_q[2*TW_BITS-1:TW_BITS]) * rd_re;
        p_ii <= $signed(tw_q[TW_BITS-1:0]) * rd_im;
        p_ri <= $signed(tw_q[2*TW_BITS-1:TW_BITS]) * rd_im;
        p_ir <= $signed(tw_q[TW_BITS-1:0]) * rd_re;
      end
      S_BF_ADD: begin
        t_re <= WB'(sum_re >>> 15);
        t_im <= WB'(sum_im >>> 15);
      end
      default: ;
    endcase
  end

  // control sequencer; swap doubles as the read/write phase of the final pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      cnt    <= '0;
      stage  <= '0;
      swap   <= 1'b0;
      e_addr <= '0;
      o_addr <= '0;
      done   <= 1'b0;
      result <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          cnt <= cnt + AW'(1);
          if (&cnt) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          cnt <= '0;
          if (start) begin
            result <= '0;
            case (req.cmd)
              CMD_READ: state <= S_READ;
              CMD_RUN:  state <= inverse ? S_PRE_RD : S_REV;
              default:  done  <= 1'b1;
            endcase
          end
        end
        S_READ: begin
          result.bin_re <= rd_re;
          result.bin_im <= rd_im;
          done          <= 1'b1;
          state         <= S_IDLE;
        end
        S_PRE_RD: state <= S_PRE_WR;
        S_PRE_WR: begin
          if (cnt == last) begin
            cnt   <= '0;
            state <= S_REV;
          end else begin
            cnt   <= cnt + AW'(1);
            state <= S_PRE_RD;
          end
        end
        S_REV: begin
          if (rev > cnt) begin
            e_addr <= cnt;
            o_addr <= rev;
            swap   <= 1'b1;
            state  <= S_RD_E;
          end else if (cnt == last) begin
            cnt   <= '0;
            stage <= LGW'(1);
            swap  <= 1'b0;
            if (lg == '0) begin
              state <= inverse ? S_POST : S_IDLE;
              done  <= !inverse;
            end else begin
              state <= S_BF_SET;
            end
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        S_BF_SET: begin
          e_addr <= bf_e;
          o_addr <= bf_e | half;
          swap   <= 1'b0;
          state  <= S_RD_E;
        end
        S_RD_E: state <= S_RD_O;
        S_RD_O: state <= swap ? S_SW_WE : S_BF_MUL;
        S_SW_WE: state <= S_SW_WO;
        S_SW_WO: begin
          // a swapping index is never the last one
          cnt   <= cnt + AW'(1);
          state <= S_REV;
        end
        S_BF_MUL: state <= S_BF_ADD;
        S_BF_ADD: state <= S_BF_WE;
        S_BF_WE:  state <= S_BF_WO;
        S_BF_WO: begin
          if (cnt == last_bf) begin
            cnt <= '0;
            if (stage == lg) begin
              swap  <= 1'b0;
              state <= inverse ? S_POST : S_IDLE;
              done  <= !inverse;
            end else begin
              stage <= stage + LGW'(1);
              state <= S_BF_SET;
            end
          end else begin
            cnt   <= cnt + AW'(1);
            state <= S_BF_SET;
          end
        end
        S_POST: begin
          // swap low reads the entry, swap high writes it back scaled
          swap <= !swap;
          if (swap) begin
            if (cnt == last) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              cnt <= cnt + AW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

import r2fft_pkg::*;

// golden model of the fft store plus the queue of result words still owed
class fft_scoreboard;
  int          store_re[1024];
  int          store_im[1024];
  int          tw_re[512];
  int          tw_im[512];
  int unsigned log_size;
  bit          inverse;
  fft_out_t    owed[$];
  int          errors;

  function new();
    log_size = 10;
    inverse  = 0;
    errors   = 0;
    foreach (store_re[i]) begin
      store_re[i] = 0;
      store_im[i] = 0;
    end
    build_twiddles();
  endfunction

  static function int wrap28(longint v);
    logic signed [27:0] w;
    w = v[27:0];
    return int'(w);
  endfunction

  static function int to_q15(longint c);
    longint unsigned u;
    if (c < 0) begin
      u = 0;
    end else if (c > (longint'(1) << 30)) begin
      u = longint'(1) << 30;
    end else begin
      u = c;
    end
    return int'((u * 32767 + (longint'(1) << 29)) >> 30);
  endfunction

  // cos/sin by truncated taylor series on a 30-bit fraction grid
  function void build_twiddles();
    longint unsigned pi_q30, m, x, t;
    longint          c, s;
    int unsigned     n;
    bit              mirror;
    int              cq, sq;
    pi_q30 = 64'd3373259426;
    for (int k = 0; k < 512; k++) begin
      m = k;
      mirror = 0;
      if (4 * k > 1024) begin
        m = 512 - k;
        mirror = 1;
      end
      x = (m * 2 * pi_q30) / 1024;
      c = longint'(1) << 30;
      t = longint'(1) << 30;
      for (n = 2; n <= 24; n += 2) begin
        t = (t * x) >> 30;
        t = ((t * x) >> 30) / ((n - 1) * n);
        if (((n / 2) & 1) != 0) c = c - longint'(t);
        else c = c + longint'(t);
      end
      s = longint'(x);
      t = x;
      for (n = 3; n <= 25; n += 2) begin
        t = (t * x) >> 30;
        t = ((t * x) >> 30) / ((n - 1) * n);
        if ((((n - 1) / 2) & 1) != 0) s = s - longint'(t);
        else s = s + longint'(t);
      end
      cq = to_q15(c);
      sq = to_q15(s);
      tw_re[k] = mirror ? -cq : cq;
      tw_im[k] = -sq;
    end
  endfunction

  function void conj(int unsigned n);
    for (int i = 0; i < n; i++) store_im[i] = wrap28(-longint'(store_im[i]));
  endfunction

  function void dit(int unsigned lg);
    int unsigned n, r, half, stride, e, o;
    int          a, b;
    longint      wr, wi, orr, oi, tr, ti, er, ei;
    n = 1 << lg;
    for (int unsigned i = 0; i < n; i++) begin
      r = 0;
      for (int unsigned q = 0; q < lg; q++) r |= ((i >> q) & 1) << (lg - 1 - q);
      if (r > i) begin
        a = store_re[i];
        b = store_im[i];
        store_re[i] = store_re[r];
        store_im[i] = store_im[r];
        store_re[r] = a;
        store_im[r] = b;
      end
    end
    for (int unsigned len = 2; len <= n; len <<= 1) begin
      half = len / 2;
      stride = 1024 / len;
      for (int unsigned base = 0; base < n; base += len) begin
        for (int unsigned j = 0; j < half; j++) begin
          e = base + j;
          o = e + half;
          wr = tw_re[j * stride];
          wi = tw_im[j * stride];
          orr = store_re[o];
          oi = store_im[o];
          tr = (wr * orr - wi * oi + 16384) >>> 15;
          ti = (wr * oi + wi * orr + 16384) >>> 15;
          er = store_re[e];
          ei = store_im[e];
          store_re[e] = wrap28(er + tr);
          store_im[e] = wrap28(ei + ti);
          store_re[o] = wrap28(er - tr);
          store_im[o] = wrap28(ei - ti);
        end
      end
    end
  endfunction

  function void transform();
    int unsigned lg, n;
    longint      h;
    lg = (log_size > 10) ? 10 : log_size;
    n = 1 << lg;
    if (!inverse) begin
      dit(lg);
      return;
    end
    conj(n);
    dit(lg);
    conj(n);
    if (lg == 0) return;
    h = longint'(1) << (lg - 1);
    for (int i = 0; i < n; i++) begin
      store_re[i] = wrap28((longint'(store_re[i]) + h) >>> lg);
      store_im[i] = wrap28((longint'(store_im[i]) + h) >>> lg);
    end
  endfunction

  // accepted command word: update the store and queue the answer it owes
  function void note(fft_in_t w);
    fft_out_t r;
    r = '0;
    case (w.cmd)
      CMD_WRITE: begin
        store_re[w.index] = int'(w.sample_re);
        store_im[w.index] = int'(w.sample_im);
      end
      CMD_RUN: transform();
      CMD_READ: begin
        r.bin_re = 28'(store_re[w.index]);
        r.bin_im = 28'(store_im[w.index]);
      end
      default: ;
    endcase
    owed = {owed, r};
  endfunction

  function void check(fft_out_t got);
    fft_out_t want;
    if (owed.size() == 0) begin
      $error("result word with nothing expected: %h", got);
      errors++;
      return;
    end
    want = owed.pop_front();
    if (got.bin_re !== want.bin_re) begin
      $error("bin_re: expected %0d, got %0d", want.bin_re, got.bin_re);
      errors++;
    end
    if (got.bin_im !== want.bin_im) begin
      $error("bin_im: expected %0d, got %0d", want.bin_im, got.bin_im);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam logic [1:0] CMD_NOP       = 2'd3;
  localparam logic [2:0] ADDR_LOG_SIZE = {REG_LOG_SIZE, 2'b00};
  localparam logic [2:0] ADDR_INVERSE  = {REG_INVERSE, 2'b00};
  localparam int         N_WORDS       = 1400;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  fft_in_t     req = '0;
  logic        done;
  fft_out_t    result;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fft_scoreboard sb = new();
  int            sent = 0;

  radix2_fft_inplace DUT (
    .clk, .rst, .start, .busy, .req, .done, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // results cannot be stalled: grab every done strobe
  always @(posedge clk) begin
    if (!rst && done) sb.check(result);
  end

  // hard stop in case the block hangs
  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  // sender idle rate: light, then heavy, then none
  function automatic int idle_pct();
    if (sent < N_WORDS / 3) return 19;
    if (sent < 2 * N_WORDS / 3) return 85;
    return 0;
  endfunction

  // present one command word and hold it until the block takes it
  task automatic issue(logic [1:0] cmd, int idx);
    fft_in_t w;
    w.cmd = cmd;
    w.index = idx[9:0];
    case ($urandom_range(7))
      0: w.sample_re = 16'sh8000;
      1: w.sample_re = 16'sh7fff;
      default: w.sample_re = 16'($urandom);
    endcase
    case ($urandom_range(7))
      0: w.sample_im = 16'sh8000;
      1: w.sample_im = 16'sh7fff;
      default: w.sample_im = 16'($urandom);
    endcase
    start <= 1;
    req <= w;
    do @(posedge clk); while (busy);
    sb.note(w);
    sent++;
    if ($urandom_range(99) < idle_pct()) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // idle point: nothing owed, nothing running
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.owed.size() != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] addr, int unsigned val);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (addr == ADDR_LOG_SIZE) sb.log_size = val & 4'hf;
    else sb.inverse = val[0];
  endtask

  task automatic set_mode(int unsigned lg, bit inv);
    drain();
    reg_write(ADDR_LOG_SIZE, lg);
    reg_write(ADDR_INVERSE, inv);
  endtask

  // one well-formed frame: load, transform, read back, with some noise
  task automatic frame();
    int unsigned lg, n, cnt;
    lg = (sb.log_size > 10) ? 10 : sb.log_size;
    n = 1 << lg;
    cnt = (n < 24) ? n : 24;
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(9) == 0) issue(CMD_NOP, $urandom_range(1023));
      issue(CMD_WRITE, (n <= 24) ? i : $urandom_range(n - 1));
    end
    // a stray write at any index, maybe past the transform length, where it must survive the run
    if ($urandom_range(3) == 0) issue(CMD_WRITE, $urandom_range(1023));
    issue(CMD_RUN, $urandom_range(1023));
    if (lg <= 6 && $urandom_range(3) == 0) issue(CMD_RUN, $urandom_range(1023));
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(9) == 0) issue(CMD_NOP, $urandom_range(1023));
      issue(CMD_READ, (n <= 24) ? i : $urandom_range(1023));
    end
  endtask

  initial begin
    int unsigned lg;
    repeat (11) @(posedge clk);
    rst <= 0;

    // directed: reset mode, field extremes, every command
    issue(CMD_READ, 5);
    issue(CMD_WRITE, 0);
    issue(CMD_WRITE, 1023);
    issue(CMD_WRITE, 512);
    issue(CMD_NOP, 1023);
    issue(CMD_READ, 1023);
    issue(CMD_READ, 0);
    issue(CMD_RUN, 0);
    issue(CMD_READ, 0);
    issue(CMD_READ, 1);
    issue(CMD_READ, 512);
    issue(CMD_READ, 1023);
    issue(CMD_NOP, 0);

    // directed modes: identity both ways, full size inverse, oversized length, two-point inverse
    set_mode(0, 0);
    frame();
    set_mode(0, 1);
    frame();
    set_mode(10, 1);
    frame();
    set_mode(15, 0);
    frame();
    set_mode(1, 1);
    frame();

    // random modes, mostly short lengths to keep runs quick
    while (sent < N_WORDS) begin
      if ($urandom_range(11) == 0) lg = $urandom_range(7, 15);
      else lg = $urandom_range(0, 5);
      set_mode(lg, $urandom_range(1));
      frame();
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
